FILE: hw/rtl/srsp_pkg.sv
// shared constants and types for the sensor record stream parser
// no dependencies; imported by srsp_id_match, sensor_record_stream_parser and the testbench files

package srsp_pkg;

   // parser phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_NEWLEN  = 3'd1;
   localparam logic [2:0] PH_ID_HI   = 3'd2;
   localparam logic [2:0] PH_ID_LO   = 3'd3;
   localparam logic [2:0] PH_REC_LEN = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   // csr register indexes
   localparam logic [2:0] REG_MESSAGE_ID  = 3'd0;
   localparam logic [2:0] REG_EULER_ID    = 3'd1;
   localparam logic [2:0] REG_ACCEL_ID    = 3'd2;
   localparam logic [2:0] REG_RATE_ID     = 3'd3;
   localparam logic [2:0] REG_POSITION_ID = 3'd4;

   localparam logic [7:0]  MESSAGE_ID_RST  = 8'd54;
   localparam logic [15:0] EULER_ID_RST    = 16'd8240;
   localparam logic [15:0] ACCEL_ID_RST    = 16'd16416;
   localparam logic [15:0] RATE_ID_RST     = 16'd32800;
   localparam logic [15:0] POSITION_ID_RST = 16'd20544;

   // matched record kind, quantity + 1, zero for no match
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_EULER    = 3'd1;
   localparam logic [2:0] KIND_ACCEL    = 3'd2;
   localparam logic [2:0] KIND_RATE     = 3'd3;
   localparam logic [2:0] KIND_POSITION = 3'd4;

   // quantity code of the latitude longitude pair
   localparam logic [1:0] QTY_LATLON = 2'd3;

   localparam logic [7:0] HEADER_BYTES = 8'd3;
   localparam logic [5:0] TRIPLE_WORDS = 6'd3;
   localparam logic [5:0] PAIR_WORDS   = 6'd2;

   typedef struct packed {
      logic [15:0] euler_id;
      logic [15:0] accel_id;
      logic [15:0] rate_id;
      logic [15:0] position_id;
   } id_regs_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
   } match_type;

endpackage

FILE: hw/rtl/srsp_id_match.sv
// record id lookup against the four id registers, first match wins
// depends on srsp_pkg

module srsp_id_match (
   input  logic [15:0]          record_id,
   input  srsp_pkg::id_regs_type ids,
   output srsp_pkg::match_type  match
);
   import srsp_pkg::*;

   always_comb begin
      match.hit  = 1'b1;
      match.kind = KIND_NONE;
      if (record_id == ids.euler_id) begin
         match.kind = KIND_EULER;
      end else if (record_id == ids.accel_id) begin
         match.kind = KIND_ACCEL;
      end else if (record_id == ids.rate_id) begin
         match.kind = KIND_RATE;
      end else if (record_id == ids.position_id) begin
         match.kind = KIND_POSITION;
      end else begin
         match.hit = 1'b0;
      end
   end

endmodule

FILE: hw/rtl/sensor_record_stream_parser.sv
// top level of the sensor record stream parser: byte state machine, csr file, result register
// depends on srsp_pkg and srsp_id_match
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, data_byte, start, len  | in, one packet byte per transaction
//   rsp     | rsp_valid/ready, quantity..record_last  | out, one float word per transaction
//   csr     | csr_write_en, csr_index, csr_wdata      | in, write only, no wait
//
// one byte per cycle while req_ready is high; a byte is taken in the same cycle its state update is computed
// a completed float word sits in the result register from the cycle after its last byte is taken
// req_ready drops only while a result is held and rsp_ready is low
// reset is synchronous and returns the parser to idle with default id registers

module sensor_record_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_start,
   input  logic [7:0]  req_packet_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_quantity,
   output logic [1:0]  rsp_component,
   output logic [31:0] rsp_value_bits,
   output logic        rsp_record_last,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import srsp_pkg::*;

   logic [7:0]  message_id_ff;
   id_regs_type ids_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] record_id_ff, record_id_in;
   logic [7:0]  record_len_ff, record_len_in;
   logic [7:0]  record_pos_ff, record_pos_in;
   logic [23:0] word_bytes_ff, word_bytes_in;
   logic [2:0]  kind_ff, kind_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  quantity_ff, quantity_in;
   logic [1:0]  component_ff, component_in;
   logic [31:0] value_ff, value_in;
   logic        last_ff, last_in;

   logic        fire;
   logic        emit;
   match_type   match;
   logic [7:0]  bl_dec;
   logic [7:0]  bl_after;
   logic [7:0]  pos_inc;
   logic [31:0] word;
   logic [5:0]  comp;
   logic [5:0]  count;
   logic [5:0]  fit;
   logic [5:0]  last_comp;

   srsp_id_match u_match (
      .record_id (record_id_ff),
      .ids       (ids_ff),
      .match     (match)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   assign bl_dec    = bytes_left_ff - 8'd1;
   assign bl_after  = bl_dec - req_data_byte;
   assign pos_inc   = record_pos_ff + 8'd1;
   assign word      = {word_bytes_ff, req_data_byte};
   assign comp      = record_pos_ff[7:2];
   assign count     = (kind_ff == KIND_POSITION) ? PAIR_WORDS : TRIPLE_WORDS;
   assign fit       = record_len_ff[7:2];
   assign last_comp = (fit < count) ? fit : count;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      record_id_in  = record_id_ff;
      record_len_in = record_len_ff;
      record_pos_in = record_pos_ff;
      word_bytes_in = word_bytes_ff;
      kind_in       = kind_ff;
      emit          = 1'b0;
      if (fire) begin
         if (req_packet_start) begin
            if (req_packet_length < 8'd2) begin
               phase_in = PH_IDLE;
            end else if (req_data_byte == message_id_ff) begin
               phase_in = PH_NEWLEN;
            end else if (req_packet_length < HEADER_BYTES) begin
               phase_in = PH_IDLE;
            end else begin
               record_id_in  = {req_data_byte, 8'h00};
               bytes_left_in = req_packet_length - 8'd1;
               phase_in      = PH_ID_LO;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_NEWLEN: begin
                  if (req_data_byte < HEADER_BYTES) begin
                     phase_in = PH_IDLE;
                  end else begin
                     bytes_left_in = req_data_byte;
                     phase_in      = PH_ID_HI;
                  end
               end
               PH_ID_HI: begin
                  record_id_in  = {req_data_byte, 8'h00};
                  bytes_left_in = bl_dec;
                  phase_in      = PH_ID_LO;
               end
               PH_ID_LO: begin
                  record_id_in  = {record_id_ff[15:8], req_data_byte};
                  bytes_left_in = bl_dec;
                  phase_in      = PH_REC_LEN;
               end
               PH_REC_LEN: begin
                  bytes_left_in = bl_dec;
                  // a record longer than the rest of the packet ends parsing
                  if (req_data_byte > bl_dec) begin
                     phase_in = PH_IDLE;
                  end else begin
                     record_len_in = req_data_byte;
                     record_pos_in = 8'd0;
                     word_bytes_in = 24'd0;
                     kind_in       = match.hit ? match.kind : KIND_NONE;
                     bytes_left_in = bl_after;
                     if (req_data_byte == 8'd0) begin
                        phase_in = (bl_after < HEADER_BYTES) ? PH_IDLE : PH_ID_HI;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  word_bytes_in = word[23:0];
                  emit = (kind_ff != KIND_NONE) && (record_pos_ff[1:0] == 2'b11)
                         && (comp < count);
                  record_pos_in = pos_inc;
                  if (pos_inc >= record_len_ff) begin
                     phase_in = (bytes_left_ff < HEADER_BYTES) ? PH_IDLE : PH_ID_HI;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = fire ? emit : (rsp_valid_ff && !rsp_ready);
      quantity_in  = kind_ff[1:0] - 2'd1;
      component_in = comp[1:0];
      value_in     = word;
      last_in      = (comp + 6'd1) == last_comp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         message_id_ff      <= MESSAGE_ID_RST;
         ids_ff.euler_id    <= EULER_ID_RST;
         ids_ff.accel_id    <= ACCEL_ID_RST;
         ids_ff.rate_id     <= RATE_ID_RST;
         ids_ff.position_id <= POSITION_ID_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MESSAGE_ID:  message_id_ff      <= csr_wdata[7:0];
            REG_EULER_ID:    ids_ff.euler_id    <= csr_wdata;
            REG_ACCEL_ID:    ids_ff.accel_id    <= csr_wdata;
            REG_RATE_ID:     ids_ff.rate_id     <= csr_wdata;
            REG_POSITION_ID: ids_ff.position_id <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= 8'd0;
         record_id_ff  <= 16'd0;
         record_len_ff <= 8'd0;
         record_pos_ff <= 8'd0;
         word_bytes_ff <= 24'd0;
         kind_ff       <= KIND_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         record_id_ff  <= record_id_in;
         record_len_ff <= record_len_in;
         record_pos_ff <= record_pos_in;
         word_bytes_ff <= word_bytes_in;
         kind_ff       <= kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new word
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         quantity_ff  <= quantity_in;
         component_ff <= component_in;
         value_ff     <= value_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quantity    = quantity_ff;
   assign rsp_component   = component_ff;
   assign rsp_value_bits  = value_ff;
   assign rsp_record_last = last_ff;

   // component index stays within the record's word count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (component_ff <= 2'd2))
      else $error("component index out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (quantity_ff == QTY_LATLON) |-> (component_ff <= 2'd1))
      else $error("latlon record gave a third component");

   // only payload bytes can produce a word
   assert property (@(posedge clock) disable iff (reset)
      fire && (req_packet_start || (phase_ff != PH_PAYLOAD)) |=> !rsp_valid_ff)
      else $error("result from a header byte");

   // stray bytes while idle leave the parser idle
   assert property (@(posedge clock) disable iff (reset)
      fire && !req_packet_start && (phase_ff == PH_IDLE) |=> (phase_ff == PH_IDLE))
      else $error("stray byte left idle");

endmodule

FILE: verif/srsp_word_board_pkg.sv
// float word scoreboard for the sensor record stream parser testbench
// byte-level parse prediction with its own copy of the id registers
// depends on srsp_pkg for phase, kind, register and reset constants
`timescale 1ns / 1ps

package srsp_word_board_pkg;
   import srsp_pkg::*;

   typedef struct {
      logic [1:0]  quantity;
      logic [1:0]  component;
      logic [31:0] value_bits;
      logic        record_last;
   } float_word_type;

   class float_word_board;
      logic [7:0]  message_id;
      logic [15:0] euler_id, accel_id, rate_id, position_id;
      logic [2:0]  phase;
      logic [7:0]  bytes_left;
      logic [15:0] record_id;
      logic [7:0]  record_len;
      logic [7:0]  record_pos;
      logic [23:0] word_bytes;
      logic [2:0]  matched_kind;
      float_word_type words_due[$];
      int mismatches;

      function new();
         message_id   = MESSAGE_ID_RST;
         euler_id     = EULER_ID_RST;
         accel_id     = ACCEL_ID_RST;
         rate_id      = RATE_ID_RST;
         position_id  = POSITION_ID_RST;
         phase        = PH_IDLE;
         bytes_left   = '0;
         record_id    = '0;
         record_len   = '0;
         record_pos   = '0;
         word_bytes   = '0;
         matched_kind = KIND_NONE;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [15:0] value);
         case (index)
            REG_MESSAGE_ID:  message_id  = value[7:0];
            REG_EULER_ID:    euler_id    = value;
            REG_ACCEL_ID:    accel_id    = value;
            REG_RATE_ID:     rate_id     = value;
            REG_POSITION_ID: position_id = value;
            default: ;
         endcase
      endfunction

      // first match wins when several registers hold the same id
      function logic [2:0] kind_of(logic [15:0] id);
         if (id == euler_id) return KIND_EULER;
         if (id == accel_id) return KIND_ACCEL;
         if (id == rate_id) return KIND_RATE;
         if (id == position_id) return KIND_POSITION;
         return KIND_NONE;
      endfunction

      function void close_record();
         phase = (bytes_left < HEADER_BYTES) ? PH_IDLE : PH_ID_HI;
      endfunction

      task flag(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // notes one accepted byte transaction and queues the word it completes
      function void take_byte(logic [7:0] d, logic start, logic [7:0] plen);
         logic [31:0]    word;
         logic [5:0]     comp, count, fit, last;
         float_word_type w;
         if (start) begin
            if (plen < 8'd2) phase = PH_IDLE;
            else if (d == message_id) phase = PH_NEWLEN;
            else if (plen < HEADER_BYTES) phase = PH_IDLE;
            else begin
               record_id  = {d, 8'h00};
               bytes_left = plen - 8'd1;
               phase      = PH_ID_LO;
            end
            return;
         end
         case (phase)
            PH_NEWLEN: begin
               if (d < HEADER_BYTES) phase = PH_IDLE;
               else begin
                  bytes_left = d;
                  phase      = PH_ID_HI;
               end
            end
            PH_ID_HI: begin
               record_id  = {d, 8'h00};
               bytes_left = bytes_left - 8'd1;
               phase      = PH_ID_LO;
            end
            PH_ID_LO: begin
               record_id  = {record_id[15:8], d};
               bytes_left = bytes_left - 8'd1;
               phase      = PH_REC_LEN;
            end
            PH_REC_LEN: begin
               bytes_left = bytes_left - 8'd1;
               // record longer than what is left of the packet stops parsing
               if (d > bytes_left) phase = PH_IDLE;
               else begin
                  record_len   = d;
                  record_pos   = '0;
                  word_bytes   = '0;
                  matched_kind = kind_of(record_id);
                  bytes_left   = bytes_left - d;
                  if (d == 8'd0) close_record();
                  else phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               word       = {word_bytes, d};
               word_bytes = word[23:0];
               if (matched_kind != KIND_NONE && record_pos[1:0] == 2'd3) begin
                  comp  = record_pos[7:2];
                  count = (matched_kind == KIND_POSITION) ? PAIR_WORDS : TRIPLE_WORDS;
                  fit   = record_len[7:2];
                  last  = (fit < count) ? fit : count;
                  if (comp < count) begin
                     w.quantity    = 2'(matched_kind - 3'd1);
                     w.component   = comp[1:0];
                     w.value_bits  = word;
                     w.record_last = (comp + 6'd1 == last);
                     words_due.push_back(w);
                  end
               end
               record_pos = record_pos + 8'd1;
               if (record_pos >= record_len) close_record();
            end
            default: phase = PH_IDLE;
         endcase
      endfunction

      task check_word(float_word_type got);
         float_word_type want;
         if (words_due.size() == 0) begin
            flag($sformatf("word %h with nothing expected", got.value_bits));
            return;
         end
         want = words_due.pop_front();
         if (got.quantity !== want.quantity)
            flag($sformatf("quantity got %0d want %0d", got.quantity, want.quantity));
         if (got.component !== want.component)
            flag($sformatf("component got %0d want %0d", got.component, want.component));
         if (got.value_bits !== want.value_bits)
            flag($sformatf("value_bits got %h want %h", got.value_bits, want.value_bits));
         if (got.record_last !== want.record_last)
            flag($sformatf("record_last got %b want %b", got.record_last, want.record_last));
      endtask
   endclass

endpackage

FILE: verif/tb_sensor_record_stream_parser.sv
// testbench top for sensor_record_stream_parser: random packets of id/length records
// driven byte by byte, float words checked against the scoreboard prediction
// depends on srsp_pkg, srsp_word_board_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_sensor_record_stream_parser;
   import srsp_pkg::*;
   import srsp_word_board_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_BYTES = 330;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_packet_start = 1'b0;
   logic [7:0]  req_packet_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_quantity;
   logic [1:0]  rsp_component;
   logic [31:0] rsp_value_bits;
   logic        rsp_record_last;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   float_word_board board;
   logic [7:0]  message_lead;
   logic [15:0] id_of_kind [4];
   logic        req_fire = 1'b0;
   int          burst_left = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int unsigned ready_mode = 0, ready_left = 0, ready_tick = 0;
   logic [7:0]  ready_mask = 8'hFF;

   sensor_record_stream_parser dut (.*);

   always #4 clock = ~clock;

   // transactions are sampled on the falling edge ahead of the rising edge that takes them
   always @(negedge clock) begin
      float_word_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.quantity    = rsp_quantity;
            got.component   = rsp_component;
            got.value_bits  = rsp_value_bits;
            got.record_last = rsp_record_last;
            board.check_word(got);
         end
         req_fire = req_valid && req_ready;
         if (req_fire) board.take_byte(req_data_byte, req_packet_start, req_packet_length);
         if (req_fire || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver stall pattern, with mode and mask chosen anew at random whenever the current run is spent
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(40, 300);
         ready_mask = 8'($urandom) | 8'h01;
      end
      ready_left--;
      ready_tick++;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ready_mask[ready_tick % 8];
      endcase
   end

   task automatic send_byte(logic [7:0] d, logic start, logic [7:0] plen);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 64);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= d;
      req_packet_start  <= start;
      req_packet_length <= plen;
      @(posedge clock);
      while (!req_fire) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // sender idle and every word delivered, then a wait for the result register
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      board.write_reg(index, value);
   endtask

   task automatic load_ids(logic [7:0] m, logic [15:0] e, logic [15:0] a,
                           logic [15:0] r, logic [15:0] p);
      write_reg(REG_MESSAGE_ID, {8'h00, m});
      write_reg(REG_EULER_ID, e);
      write_reg(REG_ACCEL_ID, a);
      write_reg(REG_RATE_ID, r);
      write_reg(REG_POSITION_ID, p);
      csr_write_en <= 1'b0;
      message_lead  = m;
      id_of_kind[0] = e;
      id_of_kind[1] = a;
      id_of_kind[2] = r;
      id_of_kind[3] = p;
   endtask

   // one packet of records, mostly well formed, sometimes wrapped, cut short or mislabelled
   task automatic send_packet();
      logic [7:0]  body[$];
      logic [15:0] id;
      logic [7:0]  decl;
      int          nrec, r, len, sel, fill, cut, i, mode;
      bit          wrapped;
      wrapped = ($urandom_range(0, 3) == 0);
      nrec = $urandom_range(wrapped ? 0 : 1, 5);
      for (r = 0; r < nrec; r++) begin
         sel = $urandom_range(0, 9);
         if (sel < 8) begin
            id  = id_of_kind[sel / 2];
            len = (sel >= 6) ? 8 : 12;
         end else begin
            id  = 16'($urandom);
            len = $urandom_range(0, 12);
         end
         case ($urandom_range(0, 9))
            6, 7: len = $urandom_range(0, 16);
            8: len = 0;
            9: len = $urandom_range(17, 60);
            default: ;
         endcase
         if (body.size() + 3 + len > 250) break;
         fill = $urandom_range(0, 5);
         body.push_back(id[15:8]);
         body.push_back(id[7:0]);
         body.push_back(8'(len));
         repeat (len)
            body.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
      end
      decl = 8'(body.size());
      cut  = body.size();
      mode = $urandom_range(0, 15);
      case (mode)
         0: decl = 8'($urandom_range(0, body.size()));
         1: if (cut > 0) cut = $urandom_range(1, cut);
         2: decl = 8'($urandom);
         default: ;
      endcase
      if (wrapped) begin
         send_byte(message_lead, 1'b1,
                   mode == 3 ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255)));
         send_byte(decl, 1'b0, 8'($urandom));
         for (i = 0; i < cut; i++) send_byte(body[i], 1'b0, 8'($urandom));
      end else begin
         for (i = 0; i < cut; i++)
            send_byte(body[i], i == 0, i == 0 ? decl : 8'($urandom));
      end
   endtask

   initial begin : main
      int          p, phase_start, noise;
      logic [15:0] x, y;
      board = new();
      message_lead  = MESSAGE_ID_RST;
      id_of_kind[0] = EULER_ID_RST;
      id_of_kind[1] = ACCEL_ID_RST;
      id_of_kind[2] = RATE_ID_RST;
      id_of_kind[3] = POSITION_ID_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stray byte, too short for anything, too short for a header
      send_byte(8'hA5, 1'b0, 8'h00);
      send_byte(8'h20, 1'b1, 8'd1);
      send_byte(8'h20, 1'b1, 8'd2);
      // wrapped message whose new length is below a header
      send_byte(MESSAGE_ID_RST, 1'b1, 8'd2);
      send_byte(8'd2, 1'b0, 8'hFF);
      // record overruns the replaced length
      send_byte(MESSAGE_ID_RST, 1'b1, 8'd255);
      send_byte(8'd5, 1'b0, 8'h00);
      send_byte(EULER_ID_RST[15:8], 1'b0, 8'h00);
      send_byte(EULER_ID_RST[7:0], 1'b0, 8'h00);
      send_byte(8'd9, 1'b0, 8'h00);
      // euler record with room for one word only
      send_byte(EULER_ID_RST[15:8], 1'b1, 8'd7);
      send_byte(EULER_ID_RST[7:0], 1'b0, 8'h00);
      send_byte(8'd4, 1'b0, 8'h00);
      repeat (4) send_byte(8'hFF, 1'b0, 8'hFF);
      // acceleration record cut off by a new packet start mid payload
      send_byte(ACCEL_ID_RST[15:8], 1'b1, 8'd255);
      send_byte(ACCEL_ID_RST[7:0], 1'b0, 8'h00);
      send_byte(8'd6, 1'b0, 8'h00);
      repeat (5) send_byte(8'h00, 1'b0, 8'h00);
      send_byte(8'h00, 1'b1, 8'd0);
      settle();

      for (p = 0; p < 6; p++) begin
         x = 16'($urandom);
         y = 16'($urandom);
         case (p)
            0: load_ids(MESSAGE_ID_RST, EULER_ID_RST, ACCEL_ID_RST, RATE_ID_RST,
                        POSITION_ID_RST);
            1: load_ids(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: load_ids(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            4: load_ids(8'($urandom), x, x, y, y);
            default: load_ids(8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            noise = $urandom_range(0, 19);
            if (noise == 0) send_byte(8'($urandom), 1'b0, 8'($urandom));
            else if (noise == 1) send_byte(8'($urandom), 1'($urandom), 8'($urandom));
            send_packet();
         end
         settle();
      end

      if (board.mismatches == 0 && board.words_due.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: sensor_record_stream_parser.f
hw/rtl/srsp_pkg.sv
hw/rtl/srsp_id_match.sv
hw/rtl/sensor_record_stream_parser.sv
verif/srsp_word_board_pkg.sv
verif/tb_sensor_record_stream_parser.sv
